[hw/rtl/pdm_pkg.sv]
// shared constants and types for the pwm period and duty measurement block
package pdm_pkg;

    localparam int STAMP_WIDTH_DEF = 32;
    localparam int STAMP_PORT_W    = 32;
    localparam int NS_W            = 10;
    localparam int TIME_W          = 32;
    localparam int FREQ_W          = 30;
    localparam int DUTY_W          = 17;
    localparam int STATUS_W        = 2;

    localparam logic [NS_W-1:0]   NS_PER_CLOCK_RESET = NS_W'(31);
    localparam logic [FREQ_W-1:0] NS_PER_SECOND      = FREQ_W'(1000000000);
    localparam logic [TIME_W-1:0] TIME_MAX           = '1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_SAT  = 2'd1,
        STATUS_ZERO = 2'd2
    } status_t;

endpackage

[hw/rtl/pwm_period_duty_measure.sv]
// top level of the pwm period and duty measurement block
// Usage:
// - input channel: in_valid / in_stall with channel and three capture
//   stamps (first rising, falling, next rising edge) in counter ticks
// - output channel: out_valid / out_stall with on, off and period time in
//   ns, frequency in hz, duty as unsigned q1.16 and a status code
// - ns_per_clock is written through cfg_we / cfg_wdata while idle
// - each request passes 3 front stages (tick difference, scaling
//   multiply, sum and saturation), 17 stages of the duty divider
//   and 30 stages of the frequency divider, one quotient bit per stage
// - one request per cycle is taken while in_stall is low; the last
//   divider stage is the output register
// - when out_stall holds a valid result the whole pipeline freezes and
//   in_stall rises; nothing is lost or repeated
// - reset clears all valid bits and loads ns_per_clock with 31
// - a zero period gives zero frequency and duty and the zero status
module pwm_period_duty_measure
    import pdm_pkg::*;
#(
    parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [NS_W-1:0]         cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    channel,
    input  logic [STAMP_PORT_W-1:0] edge_start,
    input  logic [STAMP_PORT_W-1:0] edge_fall,
    input  logic [STAMP_PORT_W-1:0] edge_next,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    channel_out,
    output logic [TIME_W-1:0]       on_time,
    output logic [TIME_W-1:0]       off_time,
    output logic [TIME_W-1:0]       period_time,
    output logic [FREQ_W-1:0]       frequency_hz,
    output logic [DUTY_W-1:0]       duty_fraction,
    output logic [STATUS_W-1:0]     status
);

    // scaled time widths: ticks times ns, and the sum of two
    localparam int PROD_W = STAMP_WIDTH + NS_W;
    localparam int PER_W  = PROD_W + 1;
    localparam int DUTY_PW = 1 + 3 * TIME_W + STATUS_W + PER_W;
    localparam int FREQ_PW = 1 + 3 * TIME_W + STATUS_W + DUTY_W;

    logic            en;
    logic [NS_W-1:0] ns_reg;

    // stage 1: wrapped tick differences
    logic                   s1_valid_reg;
    logic                   s1_chan_reg;
    logic [STAMP_WIDTH-1:0] s1_on_reg;
    logic [STAMP_WIDTH-1:0] s1_off_reg;

    // stage 2: scaled to ns
    logic              s2_valid_reg;
    logic              s2_chan_reg;
    logic [PROD_W-1:0] s2_on_reg;
    logic [PROD_W-1:0] s2_off_reg;

    // stage 3: period, saturation and status
    logic              s3_valid_reg;
    logic              s3_chan_reg;
    logic [PROD_W-1:0] s3_on_reg;
    logic [PER_W-1:0]  s3_per_reg;
    logic [TIME_W-1:0] s3_on_sat_reg;
    logic [TIME_W-1:0] s3_off_sat_reg;
    logic [TIME_W-1:0] s3_per_sat_reg;
    status_t           s3_status_reg;

    logic [PER_W-1:0]  per_next;
    logic              on_over;
    logic              off_over;
    logic              per_over;
    status_t           status_next;

    logic               duty_valid;
    logic [DUTY_W-1:0]  duty_quo;
    logic [DUTY_PW-1:0] duty_pay;
    logic [PER_W-1:0]   duty_per;
    logic [FREQ_PW-1:0] freq_pay_in;
    logic [FREQ_PW-1:0] freq_pay;
    logic [FREQ_W-1:0]  freq_quo;

    logic               res_chan;
    logic [TIME_W-1:0]  res_on;
    logic [TIME_W-1:0]  res_off;
    logic [TIME_W-1:0]  res_per;
    logic [STATUS_W-1:0] res_status;
    logic [DUTY_W-1:0]  res_duty;
    logic               res_zero;

    // whole pipeline moves unless a finished result is held back
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg <= NS_PER_CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            ns_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // sum of the exact times and overflow checks against 32 bits
    assign per_next = PER_W'(s2_on_reg) + PER_W'(s2_off_reg);
    assign on_over  = 64'(s2_on_reg) > 64'(TIME_MAX);
    assign off_over = 64'(s2_off_reg) > 64'(TIME_MAX);
    assign per_over = 64'(per_next) > 64'(TIME_MAX);

    always_comb
    begin
        if (per_next == '0)
            status_next = STATUS_ZERO;
        else if (on_over || off_over || per_over)
            status_next = STATUS_SAT;
        else
            status_next = STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_chan_reg    <= channel;
            s1_on_reg      <= edge_fall[STAMP_WIDTH-1:0] - edge_start[STAMP_WIDTH-1:0];
            s1_off_reg     <= edge_next[STAMP_WIDTH-1:0] - edge_fall[STAMP_WIDTH-1:0];

            s2_chan_reg    <= s1_chan_reg;
            s2_on_reg      <= PROD_W'(s1_on_reg) * PROD_W'(ns_reg);
            s2_off_reg     <= PROD_W'(s1_off_reg) * PROD_W'(ns_reg);

            s3_chan_reg    <= s2_chan_reg;
            s3_on_reg      <= s2_on_reg;
            s3_per_reg     <= per_next;
            s3_on_sat_reg  <= on_over ? TIME_MAX : TIME_W'(s2_on_reg);
            s3_off_sat_reg <= off_over ? TIME_MAX : TIME_W'(s2_off_reg);
            s3_per_sat_reg <= per_over ? TIME_MAX : TIME_W'(per_next);
            s3_status_reg  <= status_next;
        end
    end

    // duty = (on << 16) / period; on never exceeds period, so start from
    // on >> 1 and feed its low bit followed by sixteen zeros
    pdm_div #(
        .QW (DUTY_W),
        .DW (PER_W),
        .PW (DUTY_PW)
    ) u_duty_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_rem    (PER_W'(s3_on_reg >> 1)),
        .in_num    ({s3_on_reg[0], {(DUTY_W-1){1'b0}}}),
        .in_div    (s3_per_reg),
        .in_pay    ({s3_chan_reg, s3_on_sat_reg, s3_off_sat_reg, s3_per_sat_reg,
                     s3_status_reg, s3_per_reg}),
        .out_valid (duty_valid),
        .out_quo   (duty_quo),
        .out_pay   (duty_pay)
    );

    assign duty_per    = duty_pay[PER_W-1:0];
    assign freq_pay_in = {duty_pay[DUTY_PW-1:PER_W], duty_quo};

    // frequency = 1e9 / period
    pdm_div #(
        .QW (FREQ_W),
        .DW (PER_W),
        .PW (FREQ_PW)
    ) u_freq_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (duty_valid),
        .in_rem    ('0),
        .in_num    (NS_PER_SECOND),
        .in_div    (duty_per),
        .in_pay    (freq_pay_in),
        .out_valid (out_valid),
        .out_quo   (freq_quo),
        .out_pay   (freq_pay)
    );

    assign {res_chan, res_on, res_off, res_per, res_status, res_duty} = freq_pay;
    assign res_zero = (res_status == STATUS_ZERO);

    assign channel_out   = res_chan;
    assign on_time       = res_on;
    assign off_time      = res_off;
    assign period_time   = res_per;
    assign status        = res_status;
    // a zero divisor leaves all ones in the quotient, report zero instead
    assign frequency_hz  = res_zero ? '0 : freq_quo;
    assign duty_fraction = res_zero ? '0 : res_duty;

endmodule

[hw/rtl/pdm_div.sv]
// pipelined restoring divider, one quotient bit per register stage
module pdm_div
    import pdm_pkg::*;
#(
    parameter int QW = DUTY_W,
    parameter int DW = STAMP_WIDTH_DEF + NS_W + 1,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    logic [QW-1:0] valid_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] num_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] div_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          valid_prev;
        logic [DW-1:0] rem_prev;
        logic [QW-1:0] num_prev;
        logic [QW-1:0] quo_prev;
        logic [DW-1:0] div_prev;
        logic [PW-1:0] pay_prev;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_rem;
            assign num_prev   = in_num;
            assign quo_prev   = '0;
            assign div_prev   = in_div;
            assign pay_prev   = in_pay;
        end else begin : g_rest
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign num_prev   = num_reg[k-1];
            assign quo_prev   = quo_reg[k-1];
            assign div_prev   = div_reg[k-1];
            assign pay_prev   = pay_reg[k-1];
        end

        // shift in next numerator bit, subtract when it fits
        assign trial    = {rem_prev, num_prev[QW-1]};
        assign ge       = (trial >= {1'b0, div_prev});
        assign rem_next = ge ? DW'(trial - {1'b0, div_prev}) : DW'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= QW'({num_prev, 1'b0});
                quo_reg[k] <= QW'({quo_prev, ge});
                div_reg[k] <= div_prev;
                pay_reg[k] <= pay_prev;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

[tb/sv/tb.sv]
// testbench for the pwm period and duty measurement block
module tb
    import pdm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected measurement result
    typedef struct packed {
        logic              channel;
        logic [TIME_W-1:0] on_ns;
        logic [TIME_W-1:0] off_ns;
        logic [TIME_W-1:0] per_time;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic [STATUS_W-1:0] stat;
    } meas_t;

    // directed row: stimulus, register value, optional typed-in result
    typedef struct {
        logic [NS_W-1:0] ns;
        logic            ch;
        logic [31:0]     s0;
        logic [31:0]     s1;
        logic [31:0]     s2;
        bit              has_exp;
        meas_t           exp_meas;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [NS_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic channel = 1'b0;
    logic [31:0] edge_start = '0;
    logic [31:0] edge_fall = '0;
    logic [31:0] edge_next = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic channel_out;
    logic [TIME_W-1:0] on_time, off_time, period_time;
    logic [FREQ_W-1:0] frequency_hz;
    logic [DUTY_W-1:0] duty_fraction;
    logic [STATUS_W-1:0] status;

    // model copy of the scale register
    logic [NS_W-1:0] scale_ns;
    meas_t pending_meas[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    pwm_period_duty_measure dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .channel(channel),
        .edge_start(edge_start), .edge_fall(edge_fall), .edge_next(edge_next),
        .out_valid(out_valid), .out_stall(out_stall), .channel_out(channel_out),
        .on_time(on_time), .off_time(off_time), .period_time(period_time),
        .frequency_hz(frequency_hz), .duty_fraction(duty_fraction), .status(status)
    );

    always #5 clk = ~clk;

    // predictor: wrapped tick differences scaled to ns, then divided exactly
    function automatic meas_t measure_pwm(logic ch, logic [31:0] s0, logic [31:0] s1,
                                          logic [31:0] s2, logic [NS_W-1:0] ns);
        meas_t m;
        logic [31:0] on_ticks, off_ticks;
        logic [63:0] on_w, off_w, per_w;
        bit sat;
        on_ticks = s1 - s0;
        off_ticks = s2 - s1;
        on_w = 64'(on_ticks) * 64'(ns);
        off_w = 64'(off_ticks) * 64'(ns);
        per_w = on_w + off_w;
        sat = (on_w > 64'hFFFF_FFFF) || (off_w > 64'hFFFF_FFFF)
              || (per_w > 64'hFFFF_FFFF);
        m.channel = ch;
        m.on_ns = (on_w > 64'hFFFF_FFFF) ? TIME_MAX : on_w[31:0];
        m.off_ns = (off_w > 64'hFFFF_FFFF) ? TIME_MAX : off_w[31:0];
        m.per_time = (per_w > 64'hFFFF_FFFF) ? TIME_MAX : per_w[31:0];
        if (per_w == 0) begin
            m.freq = '0;
            m.duty = '0;
            m.stat = STATUS_ZERO;
        end else begin
            m.freq = FREQ_W'(64'd1000000000 / per_w);
            // on <= per, so on<<16 fits in 64 bits (on < 2^43)
            m.duty = DUTY_W'((on_w << 16) / per_w);
            m.stat = sat ? STATUS_SAT : STATUS_OK;
        end
        return m;
    endfunction

    // receiver: random stall, compare against oldest pending result
    always @(posedge clk) begin
        meas_t got;
        meas_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{channel_out, on_time, off_time, period_time,
                    frequency_hz, duty_fraction, status};
            if (pending_meas.size() == 0) begin
                $display("%0t unexpected result actual %h", $time, got);
                errors++;
            end else begin
                want = pending_meas.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                    if (got.channel !== want.channel) $display("  channel_out");
                    if (got.on_ns !== want.on_ns) $display("  on_time");
                    if (got.off_ns !== want.off_ns) $display("  off_time");
                    if (got.per_time !== want.per_time) $display("  period_time");
                    if (got.freq !== want.freq) $display("  frequency_hz");
                    if (got.duty !== want.duty) $display("  duty_fraction");
                    if (got.stat !== want.stat) $display("  status");
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // push one request, with random sender gaps; prediction at acceptance
    task automatic send_request(logic ch, logic [31:0] s0, logic [31:0] s1,
                                logic [31:0] s2, bit has_exp, meas_t exp_meas);
        meas_t m;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel <= ch;
        edge_start <= s0;
        edge_fall <= s1;
        edge_next <= s2;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        m = measure_pwm(ch, s0, s1, s2, scale_ns);
        if (has_exp && m !== exp_meas) begin
            $display("%0t predictor disagrees with table expected %h actual %h",
                     $time, exp_meas, m);
            errors++;
        end
        pending_meas.push_back(has_exp ? exp_meas : m);
        // drop valid only if the next call does not raise it in this step
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_meas.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // only written once the pipeline has drained
    task automatic write_scale(logic [NS_W-1:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        scale_ns = v;
    endtask

    // random stamps: mostly plausible short periods, some wraps and wide spans
    task automatic send_random();
        logic [31:0] s0, on_t, off_t;
        int kind;
        kind = $urandom_range(9);
        s0 = $urandom;
        case (kind)
            0: begin on_t = $urandom; off_t = $urandom; end
            1: begin on_t = '0; off_t = $urandom_range(3); end
            2: begin on_t = $urandom_range(3); off_t = '0; end
            default: begin
                on_t = $urandom_range(20000);
                off_t = $urandom_range(20000);
            end
        endcase
        send_request(1'($urandom), s0, s0 + on_t, s0 + on_t + off_t, 1'b0, '0);
    endtask

    row_t dir_rows[$];

    initial begin
        logic [NS_W-1:0] scales[6];
        scales = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd7, 10'd31};
        scale_ns = NS_PER_CLOCK_RESET;

        // after reset (31 ns): 10 ticks on, 10 off
        dir_rows.push_back('{10'd31, 1'b1, 32'd0, 32'd10, 32'd20, 1'b1,
            '{1'b1, 32'd310, 32'd310, 32'd620, 30'd1612903, 17'd32768, STATUS_OK}});
        // all stamps equal: zero period
        dir_rows.push_back('{10'd31, 1'b0, 32'd5, 32'd5, 32'd5, 1'b1,
            '{1'b0, 32'd0, 32'd0, 32'd0, 30'd0, 17'd0, STATUS_ZERO}});
        // counter wrap between edges
        dir_rows.push_back('{10'd1, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b1,
            '{1'b0, 32'd1, 32'd1, 32'd2, 30'd500000000, 17'd32768, STATUS_OK}});
        // shortest period at 1 ns, all off: max frequency
        dir_rows.push_back('{10'd1, 1'b1, 32'd0, 32'd0, 32'd1, 1'b1,
            '{1'b1, 32'd0, 32'd1, 32'd1, 30'd1000000000, 17'd0, STATUS_OK}});
        // all on: duty one
        dir_rows.push_back('{10'd1, 1'b1, 32'd0, 32'd1, 32'd1, 1'b1,
            '{1'b1, 32'd1, 32'd0, 32'd1, 30'd1000000000, 17'd65536, STATUS_OK}});
        // maximum ticks, 1000 ns: all times saturate, duty stays one half
        dir_rows.push_back('{10'd1000, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1,
            '{1'b0, TIME_MAX, TIME_MAX, TIME_MAX, 30'd0, 17'd32768, STATUS_SAT}});
        // period only saturates
        dir_rows.push_back('{10'd1, 1'b1, 32'd0, 32'h8000_0000, 32'h0000_0001, 1'b0, '0});
        dir_rows.push_back('{10'd1000, 1'b1, 32'h1234_5678, 32'h1234_5679,
                             32'hFFFF_FFFF, 1'b0, '0});
        // zero register: zero period whatever the stamps
        dir_rows.push_back('{10'd0, 1'b1, 32'd0, 32'd100, 32'd300, 1'b1,
            '{1'b1, 32'd0, 32'd0, 32'd0, 30'd0, 17'd0, STATUS_ZERO}});
        dir_rows.push_back('{10'd1023, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555,
                             32'hAAAA_AAAA, 1'b0, '0});
        dir_rows.push_back('{10'd1023, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA,
                             32'h5555_5555, 1'b0, '0});
        dir_rows.push_back('{10'd7, 1'b0, 32'd100, 32'd103, 32'd110, 1'b0, '0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].ns != scale_ns) write_scale(dir_rows[i].ns);
            send_request(dir_rows[i].ch, dir_rows[i].s0, dir_rows[i].s1,
                         dir_rows[i].s2, dir_rows[i].has_exp, dir_rows[i].exp_meas);
        end

        // three idling phases, each walking through register settings
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 82 : 0;
            recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 9 : 0;
            foreach (scales[k]) begin
                write_scale(scales[k]);
                for (int n = 0; n < 50; n++) begin
                    send_random();
                    // pressure: sender holds off until the pipeline is empty
                    if (n == 25 && k == 0) drain_results();
                end
            end
        end
        drain_results();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/pdm_pkg.sv
hw/rtl/pdm_div.sv
hw/rtl/pwm_period_duty_measure.sv
tb/sv/tb.sv
